>>> hw/rtl/msbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared constants, codes and controller/datapath handshake types for the
// MSB-first bit field reader.
// ----------------------------------------------------------------------------
package msbr_pkg;

    // Default configuration of the reader.
    localparam int FIFO_DEPTH_DEF      = 16;
    localparam int MAX_FIELD_BITS_DEF  = 32;
    localparam int MAX_FIELD_BYTES_DEF = 4;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;
    localparam int BYTE_W  = 8;
    localparam int NEED_W  = 7;   // bits still owed to a field, up to 127
    localparam int BITS_W  = 4;   // bits left in the holder, up to 8

    // Request action codes.
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_BITS  = 2'd1,
        ACT_BYTES = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNDER  = 2'd1,
        ST_TOOBIG = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_TAKE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic exec;     // check the request, push a byte or start a read
        logic pop;      // read the next byte out of the FIFO
        logic take;     // move bits from the holder into the field
        logic result;   // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go;           // the request is a read that moves bits
        logic fetch_first;  // the read starts with a fetch: aligned read or empty holder
        logic need_done;    // this take finishes the field
        logic out_free;     // the output register can take a result
    } t_dp_stat;

endpackage

>>> hw/rtl/msbr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbr request and response channels
// Valid/ready channel interfaces for the bit field reader.
// ----------------------------------------------------------------------------

// Request channel: one action with its operands.
interface msbr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [5:0] field_count;
    logic       want_signed;

    modport source (output valid, action, data_byte, field_count, want_signed,
                    input ready);
    modport sink   (input valid, action, data_byte, field_count, want_signed,
                    output ready);
endinterface

// Response channel: one field value and status per request.
interface msbr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] field_value;
    logic [1:0]  status;

    modport source (output valid, field_value, status, input ready);
    modport sink   (input valid, field_value, status, output ready);
endinterface

>>> hw/rtl/msbr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbr_ctrl
// Sequencer for the bit field reader: accepts a request, walks the datapath
// through fetch and take steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module msbr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  msbr_pkg::t_dp_stat i_stat,
    output msbr_pkg::t_dp_cmd  o_cmd
);
    import msbr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_stat.go) begin
                    n_state = S_DONE;
                end else if (i_stat.fetch_first) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_FETCH: begin
                o_cmd.pop = 1'b1;
                n_state   = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                // A take that leaves bits owed has always drained the holder.
                n_state = i_stat.need_done ? S_DONE : S_FETCH;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/msbr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbr_dp
// Datapath of the bit field reader: byte FIFO, bit holder, field
// accumulator, request checks and the output register.
// ----------------------------------------------------------------------------
module msbr_dp #(
    parameter int FIFO_DEPTH      = msbr_pkg::FIFO_DEPTH_DEF,
    parameter int MAX_FIELD_BITS  = msbr_pkg::MAX_FIELD_BITS_DEF,
    parameter int MAX_FIELD_BYTES = msbr_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_action,
    input  logic [msbr_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [msbr_pkg::COUNT_W-1:0]  i_field_count,
    input  logic                          i_want_signed,
    input  msbr_pkg::t_dp_cmd             i_cmd,
    output msbr_pkg::t_dp_stat            o_stat,
    msbr_rsp_if.source                    o_rsp
);
    import msbr_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W = (LVL_W > COUNT_W) ? LVL_W : COUNT_W;

    // Captured request.
    t_action              r_action;
    logic [BYTE_W-1:0]    r_byte;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_sgn;

    // FIFO storage and pointers.
    logic [BYTE_W-1:0]    r_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0]    r_rd_data;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [LVL_W-1:0]     r_level;

    // Bit holder and field state.
    logic [BYTE_W-1:0]    r_holder;
    logic [BITS_W-1:0]    r_bits_left;
    logic                 r_fresh;
    logic [VALUE_W-1:0]   r_acc;
    logic [NEED_W-1:0]    r_need;
    logic [NEED_W-1:0]    r_ext;
    t_status              r_status;

    // Output register.
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    t_status              r_out_status;

    // Request checks.
    logic                 w_full;
    logic [NEED_W-1:0]    w_short_sum;
    logic [3:0]           w_need_bytes;
    t_status              w_exec_status;
    logic [NEED_W-1:0]    w_exec_need;
    logic                 w_push_ok;

    // Take step.
    logic [BITS_W-1:0]    w_avail;
    logic [BYTE_W-1:0]    w_src;
    logic [BITS_W-1:0]    w_take;
    logic [BYTE_W-1:0]    w_chunk;

    // Result shaping.
    logic [4:0]           w_ext_pos;
    logic                 w_do_ext;
    logic [VALUE_W-1:0]   w_value;

    // Latch the request operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_byte   <= i_data_byte;
            r_count  <= i_field_count;
            r_sgn    <= i_want_signed;
        end
    end

    // Whole bytes a bit read must pull in beyond the bits already held.
    always_comb begin
        w_short_sum  = NEED_W'(r_count) - NEED_W'(r_bits_left) + NEED_W'(7);
        w_need_bytes = (r_count > COUNT_W'(r_bits_left)) ? w_short_sum[6:3] : 4'd0;
    end

    // Decide the outcome of the request.
    always_comb begin
        w_full        = (r_level == LVL_W'(FIFO_DEPTH));
        w_exec_status = ST_OK;
        w_exec_need   = '0;
        case (r_action)
            ACT_PUSH: begin
                if (w_full) begin
                    w_exec_status = ST_FULL;
                end
            end
            ACT_BITS: begin
                if ({1'b0, r_count} > NEED_W'(MAX_FIELD_BITS)) begin
                    w_exec_status = ST_TOOBIG;
                end else if (CMP_W'(w_need_bytes) > CMP_W'(r_level)) begin
                    w_exec_status = ST_UNDER;
                end else begin
                    w_exec_need = NEED_W'(r_count);
                end
            end
            ACT_BYTES: begin
                if (r_count > COUNT_W'(MAX_FIELD_BYTES)) begin
                    w_exec_status = ST_TOOBIG;
                end else if (CMP_W'(r_count) > CMP_W'(r_level)) begin
                    w_exec_status = ST_UNDER;
                end else begin
                    w_exec_need = {r_count[3:0], 3'b000};
                end
            end
            default: begin
                w_exec_status = ST_OK;
            end
        endcase
        w_push_ok = (r_action == ACT_PUSH) && !w_full;
    end

    // Bits available this step and how many of them go into the field.
    always_comb begin
        w_avail = r_fresh ? BITS_W'(8) : r_bits_left;
        w_src   = r_fresh ? r_rd_data : r_holder;
        w_take  = (r_need < NEED_W'(w_avail)) ? r_need[BITS_W-1:0] : w_avail;
        w_chunk = w_src >> (BITS_W'(8) - w_take);
    end

    // FIFO storage, written on push and read on pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push_ok) begin
            r_mem[r_wr_ptr] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // FIFO pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_level  <= '0;
        end else if (i_cmd.exec && w_push_ok) begin
            r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            r_level  <= r_level + 1'b1;
        end else if (i_cmd.pop) begin
            r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            r_level  <= r_level - 1'b1;
        end
    end

    // Bit holder: cleared by an aligned read, shifted by each take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holder    <= '0;
            r_bits_left <= '0;
            r_fresh     <= 1'b0;
        end else begin
            if (i_cmd.exec && (r_action == ACT_BYTES) && (w_exec_need != '0)) begin
                r_bits_left <= '0;
            end
            if (i_cmd.pop) begin
                r_fresh <= 1'b1;
            end
            if (i_cmd.take) begin
                r_holder    <= w_src << w_take;
                r_bits_left <= w_avail - w_take;
                r_fresh     <= 1'b0;
            end
        end
    end

    // Field accumulator and bookkeeping for the request in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= w_exec_status;
            r_acc    <= '0;
            r_need   <= w_exec_need;
            r_ext    <= w_exec_need;
        end else if (i_cmd.take) begin
            r_acc  <= (r_acc << w_take) | VALUE_W'(w_chunk);
            r_need <= r_need - NEED_W'(w_take);
        end
    end

    // Sign extension applies only when the field is narrower than 32 bits.
    always_comb begin
        w_ext_pos = r_ext[4:0] - 5'd1;
        w_do_ext  = r_sgn && (r_ext != '0) && (r_ext < NEED_W'(VALUE_W)) && r_acc[w_ext_pos];
        w_value   = w_do_ext ? (r_acc | ({VALUE_W{1'b1}} << r_ext[4:0])) : r_acc;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out_value  <= (r_status == ST_OK) ? w_value : '0;
            r_out_status <= r_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.field_value = r_out_value;
    assign o_rsp.status      = r_out_status;

    // Status to the controller.
    assign o_stat.go          = (w_exec_need != '0);
    assign o_stat.fetch_first = (r_action == ACT_BYTES) || (r_bits_left == '0);
    assign o_stat.need_done   = (r_need == NEED_W'(w_take));
    assign o_stat.out_free    = !r_out_valid || o_rsp.ready;

endmodule

>>> hw/rtl/msb_first_bit_field_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader
// Big-endian, MSB-first field reader over a byte stream with an internal
// byte FIFO, bit reads of 0 to 32 bits and byte-aligned integer reads.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Payload
//  i_req     in   valid/ready    action, data_byte, field_count, want_signed
//  o_rsp     out  valid/ready    field_value, status
//
//  A request is taken only while the sequencer is idle. Push, rejected and
//  zero-count requests go from the execute state to the done state, where
//  their result is loaded; a read adds a fetch (one memory read) and a take
//  state per byte popped, plus a take when leftover holder bits start it.
//  The next request is taken the cycle after the result is loaded, even if
//  the response is still waiting in the output register; a stalled response
//  holds the sequencer in its done state only once a second result is ready.
//  Reset is synchronous and active low; FIFO contents are not cleared.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader #(
    parameter int FIFO_DEPTH      = msbr_pkg::FIFO_DEPTH_DEF,
    parameter int MAX_FIELD_BITS  = msbr_pkg::MAX_FIELD_BITS_DEF,
    parameter int MAX_FIELD_BYTES = msbr_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msbr_req_if.sink    i_req,
    msbr_rsp_if.source  o_rsp
);
    import msbr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;

    // Sequencer.
    msbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    // FIFO, bit holder and result path.
    msbr_dp #(
        .FIFO_DEPTH      (FIFO_DEPTH),
        .MAX_FIELD_BITS  (MAX_FIELD_BITS),
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_req.action),
        .i_data_byte   (i_req.data_byte),
        .i_field_count (i_req.field_count),
        .i_want_signed (i_req.want_signed),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_rsp         (o_rsp)
    );

`ifndef SYNTHESIS
    // A failed or rejected request always reports a zero field.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.field_value == '0))
        else $error("nonzero field value with error status");

    // One request at a time: acceptance closes the request side.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request side open right after acceptance");

    // A new result appears only while a request is being worked on.
    a_rsp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> !$past(i_req.ready))
        else $error("response raised while the sequencer was idle");
`endif

endmodule
